@@ rtl/core/drr_pkg.sv @@
// Shared types, codes and helpers for the deficit round robin scheduler.
// No dependencies; imported by every module of the block but drr_ram.
package drr_pkg;

    localparam int DATA_W    = 16;
    localparam int DEFICIT_W = 17;
    localparam int BUDGET_W  = 18;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEFICIT_W-1:0] DEFICIT_MAX  = 17'h1FFFF;
    localparam logic [DATA_W-1:0]    QUANTUM_RST  = 16'd256;
    // 0.01 time units in 8.8 fixed point, rounded to nearest
    localparam logic [DATA_W-1:0]    IDLE_GAP_RST = 16'd3;

    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP = 2'd1;

    typedef enum logic [1:0] {
        KIND_GRANT    = 2'd0,
        KIND_ENQ_OK   = 2'd1,
        KIND_ENQ_DROP = 2'd2
    } drr_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_TSETUP,
        S_TREAD,
        S_TEVAL,
        S_TEND
    } drr_state_t;

    typedef struct packed {
        logic capture;    // latch the accepted input item
        logic setup;      // start a turn: load budget, clear counters
        logic rd_issue;   // read the head cost of the current flow
        logic grant;      // take the head packet into the pending slot
        logic enq_load;   // finish an enqueue and load its result
        logic pend_load;  // move the pending grant to the output register
        logic pend_last;  // the pending grant closes the turn
        logic turn_end;   // store deficit, advance pointer and time
    } drr_cmd_t;

    typedef struct packed {
        logic can_read;   // queue not empty, budget left, grant limit not hit
        logic fits;       // head cost fits in the remaining budget
        logic pend_valid; // a grant waits in the pending slot
        logic out_free;   // output register can be loaded this cycle
    } drr_stat_t;

    function automatic logic [DEFICIT_W-1:0] sat_deficit(input logic [BUDGET_W-1:0] v);
        logic [DEFICIT_W-1:0] r;
        if (v > BUDGET_W'(DEFICIT_MAX))
            r = DEFICIT_MAX;
        else
            r = v[DEFICIT_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/drr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/drr_ctrl.sv @@
// Sequencer for the scheduler: enqueue handling and the grant loop of a turn.
// Depends on drr_pkg; drives commands into drr_dpath and reads its status.
module drr_ctrl
    import drr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      func,
    input  drr_stat_t stat,
    output logic      in_stall,
    output drr_cmd_t  cmd
);

    drr_state_t state_reg;
    drr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = func ? S_TSETUP : S_ENQ;
                end
            end
            S_ENQ:
            begin
                if (stat.out_free)
                begin
                    cmd.enq_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TSETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_TREAD;
            end
            S_TREAD:
            begin
                if (stat.can_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_TEVAL;
                end
                else
                begin
                    state_next = S_TEND;
                end
            end
            S_TEVAL:
            begin
                if (!stat.fits)
                begin
                    state_next = S_TEND;
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    // push the older grant out, not last, and take the new one
                    cmd.grant     = 1'b1;
                    cmd.pend_load = stat.pend_valid;
                    state_next    = S_TREAD;
                end
            end
            S_TEND:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.pend_load = stat.pend_valid;
                    cmd.pend_last = 1'b1;
                    cmd.turn_end  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/drr_dpath.sv @@
// Datapath of the scheduler: per-flow state, queue memory, budget math, output register.
// Depends on drr_pkg and drr_ram; steered by drr_ctrl through drr_cmd_t.
module drr_dpath
    import drr_pkg::*;
#(
    parameter int FLOWS       = 3,
    parameter int QUEUE_DEPTH = 256,
    parameter int MAX_GRANTS  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 func,
    input  logic [1:0]           flow,
    input  logic [DATA_W-1:0]    cost,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  drr_cmd_t             cmd,
    output drr_stat_t            stat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [1:0]           grant_flow,
    output logic [DATA_W-1:0]    grant_cost,
    output logic [TIME_W-1:0]    start_time,
    output logic [DEFICIT_W-1:0] deficit_after,
    output logic                 last
);

    localparam int FLOW_W = $clog2(FLOWS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(FLOWS * QUEUE_DEPTH);
    localparam int GCNT_W = $clog2(MAX_GRANTS + 1);

    // latched input item
    logic                 func_reg, func_next;
    logic [1:0]           flow_reg, flow_next;
    logic [DATA_W-1:0]    cost_reg, cost_next;

    // configuration
    logic [DATA_W-1:0]    quantum_reg, quantum_next;
    logic [DATA_W-1:0]    idle_gap_reg, idle_gap_next;

    // per-flow and global scheduler state
    logic [PTR_W-1:0]     head_reg    [FLOWS];
    logic [PTR_W-1:0]     head_next   [FLOWS];
    logic [CNT_W-1:0]     fill_reg    [FLOWS];
    logic [CNT_W-1:0]     fill_next   [FLOWS];
    logic [DEFICIT_W-1:0] deficit_reg [FLOWS];
    logic [DEFICIT_W-1:0] deficit_next[FLOWS];
    logic [FLOW_W-1:0]    turn_ptr_reg, turn_ptr_next;
    logic [TIME_W-1:0]    time_reg, time_next;

    // turn working registers
    logic [BUDGET_W-1:0]  budget_reg, budget_next;
    logic [BUDGET_W-1:0]  served_reg, served_next;
    logic [GCNT_W-1:0]    gcnt_reg, gcnt_next;

    // pending grant, held until the next decision tells whether it is last
    logic                 pend_valid_reg, pend_valid_next;
    logic [1:0]           pend_flow_reg, pend_flow_next;
    logic [DATA_W-1:0]    pend_cost_reg, pend_cost_next;
    logic [TIME_W-1:0]    pend_start_reg, pend_start_next;
    logic [DEFICIT_W-1:0] pend_def_reg, pend_def_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    drr_kind_t            out_kind_reg, out_kind_next;
    logic [1:0]           out_flow_reg, out_flow_next;
    logic [DATA_W-1:0]    out_cost_reg, out_cost_next;
    logic [TIME_W-1:0]    out_start_reg, out_start_next;
    logic [DEFICIT_W-1:0] out_def_reg, out_def_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_range;
    logic [FLOW_W-1:0]    cur;
    logic [PTR_W-1:0]     head_cur;
    logic [CNT_W-1:0]     fill_cur;
    logic [DEFICIT_W-1:0] def_cur;
    logic                 enq_ok;
    logic [CNT_W:0]       pos_sum;
    logic [CNT_W:0]       pos_wrap;
    logic [ADDR_W-1:0]    flow_base;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [DATA_W-1:0]    store_cost;
    logic                 wr_en;
    logic [DATA_W-1:0]    rd_data;
    logic [BUDGET_W:0]    served_sum;
    logic [BUDGET_W-1:0]  left_grant;
    logic [BUDGET_W-1:0]  left_end;
    logic [PTR_W-1:0]     head_inc;
    logic [FLOW_W-1:0]    ptr_inc;
    logic                 out_free;

    // flow selection: turn pointer for a turn, the addressed flow for an enqueue
    assign in_range   = 32'(flow_reg) < FLOWS;
    assign cur        = func_reg ? turn_ptr_reg : (in_range ? FLOW_W'(flow_reg) : '0);
    assign head_cur   = head_reg[cur];
    assign fill_cur   = fill_reg[cur];
    assign def_cur    = deficit_reg[cur];
    assign enq_ok     = in_range && (fill_cur != CNT_W'(QUEUE_DEPTH));

    assign pos_sum    = (CNT_W+1)'(head_cur) + (CNT_W+1)'(fill_cur);
    assign pos_wrap   = (pos_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                        pos_sum - (CNT_W+1)'(QUEUE_DEPTH) : pos_sum;
    assign flow_base  = ADDR_W'(32'(cur) * QUEUE_DEPTH);
    assign wr_addr    = flow_base + ADDR_W'(pos_wrap);
    assign rd_addr    = flow_base + ADDR_W'(head_cur);
    assign store_cost = (cost_reg == '0) ? DATA_W'(1) : cost_reg;
    assign wr_en      = cmd.enq_load && enq_ok;

    drr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FLOWS * QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (store_cost),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // budget arithmetic on the head cost held in the RAM read register
    assign served_sum = (BUDGET_W+1)'(served_reg) + (BUDGET_W+1)'(rd_data);
    assign left_grant = budget_reg - served_sum[BUDGET_W-1:0];
    assign left_end   = budget_reg - served_reg;
    assign head_inc   = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
    assign ptr_inc    = (32'(cur) + 1 >= FLOWS) ? '0 : FLOW_W'(cur + 1'b1);
    assign out_free   = !out_valid_reg || !out_stall;

    assign stat.can_read   = (fill_cur != '0) && (served_reg < budget_reg) &&
                             (gcnt_reg < GCNT_W'(MAX_GRANTS));
    assign stat.fits       = served_sum <= (BUDGET_W+1)'(budget_reg);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    always_comb
    begin
        func_next       = func_reg;
        flow_next       = flow_reg;
        cost_next       = cost_reg;
        quantum_next    = quantum_reg;
        idle_gap_next   = idle_gap_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        deficit_next    = deficit_reg;
        turn_ptr_next   = turn_ptr_reg;
        time_next       = time_reg;
        budget_next     = budget_reg;
        served_next     = served_reg;
        gcnt_next       = gcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_flow_next  = pend_flow_reg;
        pend_cost_next  = pend_cost_reg;
        pend_start_next = pend_start_reg;
        pend_def_next   = pend_def_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_flow_next   = out_flow_reg;
        out_cost_next   = out_cost_reg;
        out_start_next  = out_start_reg;
        out_def_next    = out_def_reg;
        out_last_next   = out_last_reg;

        if (cmd.capture)
        begin
            func_next = func;
            flow_next = flow;
            cost_next = cost;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_QUANTUM:  quantum_next  = cfg_data;
                REG_IDLE_GAP: idle_gap_next = cfg_data;
                default:      ;
            endcase
        end

        if (cmd.setup)
        begin
            budget_next     = BUDGET_W'(quantum_reg) + BUDGET_W'(def_cur);
            served_next     = '0;
            gcnt_next       = '0;
            pend_valid_next = 1'b0;
        end

        if (wr_en)
        begin
            fill_next[cur] = fill_cur + 1'b1;
        end

        if (cmd.grant)
        begin
            served_next     = served_sum[BUDGET_W-1:0];
            gcnt_next       = gcnt_reg + 1'b1;
            time_next       = time_reg + TIME_W'(rd_data);
            head_next[cur]  = head_inc;
            fill_next[cur]  = fill_cur - 1'b1;
            pend_valid_next = 1'b1;
            pend_flow_next  = 2'(cur);
            pend_cost_next  = rd_data;
            pend_start_next = time_reg;
            pend_def_next   = sat_deficit(left_grant);
        end
        else if (cmd.pend_load)
        begin
            pend_valid_next = 1'b0;
        end

        if (cmd.turn_end)
        begin
            deficit_next[cur] = sat_deficit(left_end);
            turn_ptr_next     = ptr_inc;
            time_next         = time_reg + TIME_W'(idle_gap_reg);
        end

        if (cmd.enq_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = enq_ok ? KIND_ENQ_OK : KIND_ENQ_DROP;
            out_flow_next  = flow_reg;
            out_cost_next  = '0;
            out_start_next = time_reg;
            out_def_next   = in_range ? def_cur : '0;
            out_last_next  = 1'b1;
        end
        else if (cmd.pend_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_GRANT;
            out_flow_next  = pend_flow_reg;
            out_cost_next  = pend_cost_reg;
            out_start_next = pend_start_reg;
            out_def_next   = pend_def_reg;
            out_last_next  = cmd.pend_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg    <= QUANTUM_RST;
            idle_gap_reg   <= IDLE_GAP_RST;
            for (int i = 0; i < FLOWS; i++)
            begin
                head_reg[i]    <= '0;
                fill_reg[i]    <= '0;
                deficit_reg[i] <= '0;
            end
            turn_ptr_reg   <= '0;
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            quantum_reg    <= quantum_next;
            idle_gap_reg   <= idle_gap_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            deficit_reg    <= deficit_next;
            turn_ptr_reg   <= turn_ptr_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        flow_reg       <= flow_next;
        cost_reg       <= cost_next;
        budget_reg     <= budget_next;
        served_reg     <= served_next;
        gcnt_reg       <= gcnt_next;
        pend_flow_reg  <= pend_flow_next;
        pend_cost_reg  <= pend_cost_next;
        pend_start_reg <= pend_start_next;
        pend_def_reg   <= pend_def_next;
        out_kind_reg   <= out_kind_next;
        out_flow_reg   <= out_flow_next;
        out_cost_reg   <= out_cost_next;
        out_start_reg  <= out_start_next;
        out_def_reg    <= out_def_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign grant_flow    = out_flow_reg;
    assign grant_cost    = out_cost_reg;
    assign start_time    = out_start_reg;
    assign deficit_after = out_def_reg;
    assign last          = out_last_reg;

endmodule

@@ rtl/core/deficit_round_robin_scheduler_unit.sv @@
// Enqueue: the item is latched on transfer; its result is loaded into the output
// register once it is free. A turn grants, one read per grant, until a head packet
//   does not fit, the queue empties, the budget runs out or the grant limit is hit.
// One item is in work at a time; a waiting result stalls the block only when it must load.
// Reset clears pointers, counts, deficits, time and the output; queue memory is not cleared.
// Depends on drr_pkg, drr_ctrl, drr_dpath and drr_ram.
module deficit_round_robin_scheduler_unit
    import drr_pkg::*;
#(
    parameter int FLOWS       = 3,
    parameter int QUEUE_DEPTH = 256,
    parameter int MAX_GRANTS  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input item channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [1:0]           flow,
    input  logic [DATA_W-1:0]    cost,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [1:0]           grant_flow,
    output logic [DATA_W-1:0]    grant_cost,
    output logic [TIME_W-1:0]    start_time,
    output logic [DEFICIT_W-1:0] deficit_after,
    output logic                 last
);

    drr_cmd_t  cmd;
    drr_stat_t stat;

    // Config is registered. Writes must come only while the block is idle; not enforced.
    assign cfg_ready = 1'b1;

    // Sequencer: takes an item in idle, then walks the enqueue or the grant loop.
    drr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath: per-flow queues in one RAM, deficit and time bookkeeping, and
    // a one-deep pending slot so a grant leaves only once it is known whether
    // it closes the turn.
    drr_dpath #(
        .FLOWS       (FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_GRANTS  (MAX_GRANTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .flow          (flow),
        .cost          (cost),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .grant_flow    (grant_flow),
        .grant_cost    (grant_cost),
        .start_time    (start_time),
        .deficit_after (deficit_after),
        .last          (last)
    );

`ifndef ASSERT_OFF
    // Never overwrite a result that has not been transferred.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enq_load || cmd.pend_load) |-> stat.out_free)
        else $error("output register loaded while holding a stalled result");

    // A turn must drain its pending grant before a new item is taken.
    a_no_pend_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !stat.pend_valid)
        else $error("pending grant left over when accepting a new item");

    // Grant only a packet that fits in the remaining budget.
    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> stat.fits)
        else $error("grant issued for a packet exceeding the budget");

    // An accepted enqueue goes straight to the enqueue step and holds the input.
    a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !func) |=> (in_stall && !cmd.setup))
        else $error("enqueue item did not enter the enqueue step");
`endif

endmodule

@@ bench/drr_schedule_checker.sv @@
// Result checker for the deficit round robin scheduler: predicts every result from the
// accepted input items and register writes, and compares each result transfer in order.
// Depends on drr_pkg.
module drr_schedule_checker
    import drr_pkg::*;
#(
    parameter int FLOWS       = 3,
    parameter int QUEUE_DEPTH = 256,
    parameter int MAX_GRANTS  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 func,
    input  logic [1:0]           flow,
    input  logic [DATA_W-1:0]    cost,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           kind,
    input  logic [1:0]           grant_flow,
    input  logic [DATA_W-1:0]    grant_cost,
    input  logic [TIME_W-1:0]    start_time,
    input  logic [DEFICIT_W-1:0] deficit_after,
    input  logic                 last,
    output int                   mismatches,
    output int                   pending,
    output int                   grants_seen,
    output int                   drops_seen
);

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           fl;
        logic [DATA_W-1:0]    cost;
        logic [TIME_W-1:0]    start;
        logic [DEFICIT_W-1:0] deficit;
        logic                 last;
    } sched_result_t;

    sched_result_t        awaited_results[$];

    logic [DATA_W-1:0]    cost_store [FLOWS][QUEUE_DEPTH];
    int                   head_pos [FLOWS];
    int                   fill_level [FLOWS];
    logic [DEFICIT_W-1:0] flow_credit [FLOWS];
    logic [1:0]           turn_ptr;
    logic [TIME_W-1:0]    clock_now;
    logic [DATA_W-1:0]    quantum_reg;
    logic [DATA_W-1:0]    idle_gap_reg;

    function automatic logic [DEFICIT_W-1:0] clip_deficit(input logic [BUDGET_W-1:0] v);
        return (v > BUDGET_W'(DEFICIT_MAX)) ? DEFICIT_MAX : v[DEFICIT_W-1:0];
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // append one predicted result behind those already awaited
    task automatic queue_result(input sched_result_t res);
        awaited_results.insert(awaited_results.size(), res);
    endtask

    task automatic enqueue_outcome(input logic [1:0] fl, input logic [DATA_W-1:0] c);
        sched_result_t res;
        int            slot;
        res.kind    = KIND_ENQ_DROP;
        res.fl      = fl;
        res.cost    = '0;
        res.start   = clock_now;
        res.deficit = '0;
        res.last    = 1'b1;
        if (int'(fl) < FLOWS)
        begin
            res.deficit = flow_credit[fl];
            if (fill_level[fl] < QUEUE_DEPTH)
            begin
                slot = (head_pos[fl] + fill_level[fl]) % QUEUE_DEPTH;
                // a zero cost is stored as one so that every grant uses budget
                cost_store[fl][slot] = (c == '0) ? DATA_W'(1) : c;
                fill_level[fl]++;
                res.kind = KIND_ENQ_OK;
            end
        end
        queue_result(res);
    endtask

    task automatic serve_turn();
        logic [1:0]          fl;
        logic [BUDGET_W-1:0] budget;
        logic [BUDGET_W-1:0] served;
        logic [DATA_W-1:0]   head_cost;
        int                  grants;
        bit                  blocked;
        bit                  held;
        sched_result_t       held_res;
        fl      = (int'(turn_ptr) < FLOWS) ? turn_ptr : 2'd0;
        budget  = BUDGET_W'(quantum_reg) + BUDGET_W'(flow_credit[fl]);
        served  = '0;
        grants  = 0;
        blocked = 1'b0;
        held    = 1'b0;
        held_res = '0;
        while (!blocked && fill_level[fl] > 0 && served < budget && grants < MAX_GRANTS)
        begin
            head_cost = cost_store[fl][head_pos[fl]];
            if (served + BUDGET_W'(head_cost) > budget)
                blocked = 1'b1;
            else
            begin
                // hold back each grant until the next one shows it is not the final one
                if (held)
                    queue_result(held_res);
                served           = served + BUDGET_W'(head_cost);
                held_res.kind    = KIND_GRANT;
                held_res.fl      = fl;
                held_res.cost    = head_cost;
                held_res.start   = clock_now;
                held_res.deficit = clip_deficit(budget - served);
                held_res.last    = 1'b0;
                held             = 1'b1;
                grants++;
                clock_now        = clock_now + TIME_W'(head_cost);
                head_pos[fl]     = (head_pos[fl] + 1) % QUEUE_DEPTH;
                fill_level[fl]--;
            end
        end
        if (held)
        begin
            held_res.last = 1'b1;
            queue_result(held_res);
        end
        flow_credit[fl] = clip_deficit(budget - served);
        turn_ptr        = (int'(fl) + 1 >= FLOWS) ? 2'd0 : fl + 2'd1;
        clock_now       = clock_now + TIME_W'(idle_gap_reg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            for (int f = 0; f < FLOWS; f++)
            begin
                head_pos[f]    = 0;
                fill_level[f]  = 0;
                flow_credit[f] = '0;
            end
            turn_ptr     = '0;
            clock_now    = '0;
            quantum_reg  = QUANTUM_RST;
            idle_gap_reg = IDLE_GAP_RST;
            mismatches   = 0;
            grants_seen  = 0;
            drops_seen   = 0;
        end
        else
        begin
            // results first: a result never comes from an item accepted at the same edge
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0d flow %0d",
                             $time, kind, grant_flow);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(kind));
                    compare_field("grant_flow", 32'(want.fl), 32'(grant_flow));
                    compare_field("grant_cost", 32'(want.cost), 32'(grant_cost));
                    compare_field("start_time", want.start, start_time);
                    compare_field("deficit_after", 32'(want.deficit), 32'(deficit_after));
                    compare_field("last", 32'(want.last), 32'(last));
                end
                if (kind == KIND_GRANT)
                    grants_seen++;
                else if (kind == KIND_ENQ_DROP)
                    drops_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_QUANTUM)
                    quantum_reg = cfg_data;
                else if (cfg_index == REG_IDLE_GAP)
                    idle_gap_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (func)
                    serve_turn();
                else
                    enqueue_outcome(flow, cost);
            end
        end
        pending = awaited_results.size();
    end

endmodule

@@ bench/deficit_round_robin_scheduler_unit_tb.sv @@
// Top of the deficit round robin scheduler bench: clock, reset, stimulus, idling and verdict.
// Checking lives in drr_schedule_checker; depends on drr_pkg and the scheduler RTL.
module deficit_round_robin_scheduler_unit_tb;
    import drr_pkg::*;

    localparam int FLOWS           = 3;
    localparam int QUEUE_DEPTH     = 256;
    localparam int MAX_GRANTS      = 64;
    // a turn with no grant runs its setup, read, end and perhaps an evaluation step; allow some margin before a write
    localparam int SETTLE_CYCLES   = 16;
    // longest turn: a read and an evaluation per grant plus setup and wrap-up
    localparam int TAIL_CYCLES     = 2 * MAX_GRANTS + 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 func      = 1'b0;
    logic [1:0]           flow      = '0;
    logic [DATA_W-1:0]    cost      = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic [1:0]           grant_flow;
    logic [DATA_W-1:0]    grant_cost;
    logic [TIME_W-1:0]    start_time;
    logic [DEFICIT_W-1:0] deficit_after;
    logic                 last;

    int                   mismatches;
    int                   pending;
    int                   grants_seen;
    int                   drops_seen;

    // idling percentages, written only right after a rising edge
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    // toggle to ask the receiver for one long hold-off
    bit                   hold_go  = 1'b0;
    bit                   hold_ack = 1'b0;

    logic [DATA_W-1:0]    quantum_now = QUANTUM_RST;
    int                   enqueues_sent = 0;
    int                   turns_sent    = 0;
    int                   reg_writes    = 0;
    int                   quiet_cycles  = 0;

    deficit_round_robin_scheduler_unit #(
        .FLOWS       (FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_GRANTS  (MAX_GRANTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .flow          (flow),
        .cost          (cost),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .grant_flow    (grant_flow),
        .grant_cost    (grant_cost),
        .start_time    (start_time),
        .deficit_after (deficit_after),
        .last          (last)
    );

    drr_schedule_checker #(
        .FLOWS       (FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_GRANTS  (MAX_GRANTS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .flow          (flow),
        .cost          (cost),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .grant_flow    (grant_flow),
        .grant_cost    (grant_cost),
        .start_time    (start_time),
        .deficit_after (deficit_after),
        .last          (last),
        .mismatches    (mismatches),
        .pending       (pending),
        .grants_seen   (grants_seen),
        .drops_seen    (drops_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall at random each cycle, or hold off for a long stretch on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go != hold_ack)
            begin
                hold_ack = hold_go;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer. Returns right after the accepting
    // edge with valid still high; the next call or release_input drives it again.
    task automatic send_item(input logic f, input logic [1:0] fl, input logic [DATA_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        flow     <= fl;
        cost     <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f)
            turns_sent++;
        else
            enqueues_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Stop offering, wait for every outstanding result, then let the block settle.
    task automatic drain_results(input int settle);
        release_input();
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_QUANTUM)
            quantum_now = data;
        reg_writes++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly well-formed traffic: enqueues sized against the quantum and turns, with some
    // noise (bad flows, zero and full-scale costs). Pause halfway until all results land.
    task automatic send_random(input int count);
        int                cap;
        int                roll;
        logic [DATA_W-1:0] c;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_results(0);
            cap  = (quantum_now < 16) ? 16 : int'(quantum_now);
            roll = $urandom_range(0, 99);
            if (roll < 35)
                send_item(1'b1, 2'($urandom), DATA_W'($urandom));
            else if (roll < 85)
                send_item(1'b0, 2'($urandom_range(0, FLOWS - 1)), DATA_W'($urandom_range(0, cap)));
            else
            begin
                case ($urandom_range(0, 2))
                    0:       c = '0;
                    1:       c = '1;
                    default: c = DATA_W'($urandom);
                endcase
                send_item(1'b0, 2'($urandom_range(0, 3)), c);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, edge costs, bad flow, empty and blocked turns.
        // Sender idles rarely, receiver often.
        set_idling(12, 85);
        send_item(1'b0, 2'd3, 16'hFFFF);     // flow out of range: drop
        send_item(1'b1, 2'd0, 16'h0000);     // turn on an empty queue
        send_item(1'b0, 2'd0, 16'h0000);     // zero cost, stored as one
        send_item(1'b0, 2'd1, 16'hFFFF);
        send_item(1'b0, 2'd2, 16'h0100);
        send_item(1'b0, 2'd0, 16'h00FF);
        send_item(1'b0, 2'd0, 16'h8000);
        send_item(1'b1, 2'd3, 16'hFFFF);     // head does not fit: no grant
        send_item(1'b1, 2'd1, 16'hAAAA);     // exact fit
        send_item(1'b1, 2'd2, 16'h5555);     // two grants, then blocked
        send_item(1'b0, 2'd1, 16'hAAAA);
        send_item(1'b0, 2'd2, 16'h5555);
        drain_results(SETTLE_CYCLES);

        // Smallest quantum and no idle gap.
        write_reg(REG_QUANTUM, 16'd1);
        write_reg(REG_IDLE_GAP, 16'd0);
        send_item(1'b0, 2'd2, 16'h0001);
        repeat (3) send_item(1'b1, 2'($urandom), DATA_W'($urandom));
        drain_results(SETTLE_CYCLES);

        // Largest settings: queue more packets than one turn may grant behind a long
        // receiver hold-off, then drain them with turns that hit the grant limit and
        // saturate the deficits.
        write_reg(REG_QUANTUM, 16'hFFFF);
        write_reg(REG_IDLE_GAP, 16'hFFFF);
        hold_go = ~hold_go;
        repeat (MAX_GRANTS + 2) send_item(1'b0, 2'd0, DATA_W'($urandom_range(0, 3)));
        repeat (2 * FLOWS) send_item(1'b1, 2'($urandom), DATA_W'($urandom));
        drain_results(SETTLE_CYCLES);

        // Random traffic: sender idles rarely, receiver often.
        write_reg(REG_QUANTUM, 16'd512);
        write_reg(REG_IDLE_GAP, DATA_W'($urandom));
        set_idling(12, 85);
        send_random(8);
        drain_results(SETTLE_CYCLES);

        // Random traffic: the other way round, random quantum.
        write_reg(REG_QUANTUM, DATA_W'($urandom_range(1, 65535)));
        write_reg(REG_IDLE_GAP, DATA_W'($urandom));
        set_idling(85, 12);
        send_random(8);
        drain_results(SETTLE_CYCLES);

        // Random traffic at full rate, starting behind another long hold-off.
        write_reg(REG_QUANTUM, DATA_W'($urandom_range(64, 1024)));
        write_reg(REG_IDLE_GAP, 16'd3);
        set_idling(0, 0);
        hold_go = ~hold_go;
        send_random(8);
        drain_results(TAIL_CYCLES);

        $display("Run covered %0d enqueues and %0d turns under %0d register writes,",
                 enqueues_sent, turns_sent, reg_writes);
        $display("with %0d grants and %0d dropped enqueues compared.", grants_seen, drops_seen);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/drr_pkg.sv
rtl/core/drr_ram.sv
rtl/core/drr_ctrl.sv
rtl/core/drr_dpath.sv
rtl/core/deficit_round_robin_scheduler_unit.sv
bench/drr_schedule_checker.sv
bench/deficit_round_robin_scheduler_unit_tb.sv
